>>> rtl/swm_pkg.sv
// swm_pkg: shared constants, controller states and command/status types
// for the sliding window median unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

  // storage and sample sizes
  localparam int MAX_WINDOW  = 63;
  localparam int SAMPLE_BITS = 32;
  localparam int HALF_BITS   = 5;

  // index into the cell chain and the history ring
  localparam int IDX_W = $clog2(MAX_WINDOW);
  // sample count, able to hold MAX_WINDOW itself
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  // longest odd window that fits the storage
  localparam int WIN_CAP = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;

  // median select tree: groups of eight cells, then one of the groups
  localparam int LANE_W  = 3;
  localparam int LANES   = 1 << LANE_W;
  localparam int GRP_W   = IDX_W - LANE_W;
  localparam int NUM_GRP = 1 << GRP_W;

  localparam logic [HALF_BITS-1:0] HALF_RESET = HALF_BITS'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REMOVE,
    S_INSERT,
    S_GATHER,
    S_DONE
  } swm_state_e;

  typedef struct packed {
    logic capture;   // take the sample and read the leaving sample
    logic remove;    // drop the leaving sample from the cell chain
    logic insert;    // place the new sample, write the ring, step counters
    logic gather;    // first level of the median select
    logic load_out;  // load the output register
  } swm_cmd_t;

  typedef struct packed {
    logic full;      // window already holds all its samples
  } swm_sts_t;

endpackage : swm_pkg

`default_nettype wire

>>> rtl/sliding_window_median_unit.sv
// sliding_window_median_unit: top level of the sliding window median filter
// instantiates swm_ctrl and swm_dpath; uses swm_pkg
`timescale 1ns / 1ps
`default_nettype none

//  channel   direction  handshake               payload
//  input     in         in_valid_i/in_ready_o   sample_i (32 bit signed)
//  result    out        out_valid_o/out_ready_i median_o, window_full_o
//  config    in         cfg_we_i                cfg_wdata_i (window half k)
//
//  one item at a time, stepping through accept, remove leaving sample (only once
//  the window is full), insert new sample, group select and load; the sorted
//  cell chain takes removal and insertion as two shift steps, followed by the
//  two level median select tree
//  the next item is taken while a result still waits in the output register;
//  a stall on the result side only holds the load step
//  reset leaves an empty window with k = 1; ring and cells need no clearing

module sliding_window_median_unit (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // sample input
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic signed [swm_pkg::SAMPLE_BITS-1:0] sample_i,
  // result output
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic signed      [swm_pkg::SAMPLE_BITS-1:0] median_o,
  output logic                                        window_full_o,
  // window half size register, write also flushes the window
  input  wire logic                                   cfg_we_i,
  input  wire logic        [swm_pkg::HALF_BITS-1:0]   cfg_wdata_i
);

  // command and status between sequencer and datapath
  swm_pkg::swm_cmd_t cmd;
  swm_pkg::swm_sts_t sts;

  // sequencer: one item through remove, insert and select steps
  swm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: sorted cells, arrival ring, counters, median register
  swm_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .sample_i      (sample_i),
    .median_o      (median_o),
    .window_full_o (window_full_o)
  );

endmodule : sliding_window_median_unit

`default_nettype wire

>>> rtl/swm_ctrl.sv
// swm_ctrl: sequencing state machine and output valid flag
// uses swm_pkg
`timescale 1ns / 1ps
`default_nettype none

module swm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire swm_pkg::swm_sts_t sts_i,
  output swm_pkg::swm_cmd_t      cmd_o
);

  swm_pkg::swm_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.full ? swm_pkg::S_REMOVE : swm_pkg::S_INSERT;
        end
      end
      swm_pkg::S_REMOVE: state_d = swm_pkg::S_INSERT;
      swm_pkg::S_INSERT: state_d = swm_pkg::S_GATHER;
      swm_pkg::S_GATHER: state_d = swm_pkg::S_DONE;
      swm_pkg::S_DONE: begin
        if (out_free) begin
          state_d = swm_pkg::S_IDLE;
        end
      end
      default: state_d = swm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      swm_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      swm_pkg::S_REMOVE: cmd_o.remove = 1'b1;
      swm_pkg::S_INSERT: cmd_o.insert = 1'b1;
      swm_pkg::S_GATHER: cmd_o.gather = 1'b1;
      swm_pkg::S_DONE:   cmd_o.load_out = out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swm_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // output register never overwritten while a result is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

  // an accepted item blocks the input until its result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // a new result appears only through a load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd_o.load_out))
    else $error("result valid without a load");

endmodule : swm_ctrl

`default_nettype wire

>>> rtl/swm_dpath.sv
// swm_dpath: sorted cell chain, history ring, window counters,
// median select tree and output register; uses swm_pkg
`timescale 1ns / 1ps
`default_nettype none

module swm_dpath (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire swm_pkg::swm_cmd_t                      cmd_i,
  output swm_pkg::swm_sts_t                           sts_o,
  input  wire logic                                   cfg_we_i,
  input  wire logic        [swm_pkg::HALF_BITS-1:0]   cfg_wdata_i,
  input  wire logic signed [swm_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic signed      [swm_pkg::SAMPLE_BITS-1:0] median_o,
  output logic                                        window_full_o
);

  localparam int SW = swm_pkg::SAMPLE_BITS;
  localparam int MW = swm_pkg::MAX_WINDOW;

  // configuration and window bookkeeping
  logic [swm_pkg::HALF_BITS-1:0] half_q;
  logic [swm_pkg::CNT_W-1:0]     fill_q, fill_d;
  logic [swm_pkg::CNT_W-1:0]     oldest_q, oldest_d;
  logic [swm_pkg::CNT_W-1:0]     win_len;
  logic [swm_pkg::CNT_W-1:0]     slot;
  logic [swm_pkg::CNT_W-1:0]     slot_inc;
  logic [swm_pkg::CNT_W-1:0]     ins_count;
  logic [swm_pkg::IDX_W-1:0]     mid;
  logic [swm_pkg::HALF_BITS+1:0] len_raw;
  logic                          win_full;
  logic                          phase_full_q;
  logic                          res_full_q;

  // sample registers and ring
  logic signed [SW-1:0] sample_q;
  logic signed [SW-1:0] leave_q;
  logic signed [SW-1:0] ring_mem [MW];
  logic [swm_pkg::IDX_W-1:0] wr_addr;

  // cell chain
  logic signed [SW-1:0] cell_q [MW];
  logic signed [SW-1:0] cell_d [MW];
  logic                 gt     [MW];
  logic                 ge     [MW];

  // median select tree
  logic signed [SW-1:0] cell_pad [swm_pkg::NUM_GRP * swm_pkg::LANES];
  logic signed [SW-1:0] grp_q    [swm_pkg::NUM_GRP];
  logic signed [SW-1:0] median_q;
  logic                 full_out_q;

  // window length 2k+1, clamped to the storage
  assign len_raw = {1'b0, half_q, 1'b1};
  assign win_len = (len_raw > (swm_pkg::HALF_BITS + 2)'(swm_pkg::WIN_CAP))
                 ? swm_pkg::CNT_W'(swm_pkg::WIN_CAP)
                 : swm_pkg::CNT_W'(len_raw);
  assign mid      = swm_pkg::IDX_W'((win_len - swm_pkg::CNT_W'(1)) >> 1);
  assign win_full = (fill_q >= win_len);
  assign sts_o.full = win_full;

  assign slot      = (oldest_q < win_len) ? oldest_q : '0;
  assign slot_inc  = slot + swm_pkg::CNT_W'(1);
  assign ins_count = phase_full_q ? (win_len - swm_pkg::CNT_W'(1)) : fill_q;
  assign wr_addr   = phase_full_q ? slot[swm_pkg::IDX_W-1:0] : fill_q[swm_pkg::IDX_W-1:0];

  // counters
  always_comb begin
    fill_d   = fill_q;
    oldest_d = oldest_q;
    if (cfg_we_i) begin
      fill_d   = '0;
      oldest_d = '0;
    end else if (cmd_i.insert) begin
      if (phase_full_q) begin
        oldest_d = (slot_inc >= win_len) ? '0 : slot_inc;
      end else begin
        fill_d   = fill_q + swm_pkg::CNT_W'(1);
        oldest_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q   <= swm_pkg::HALF_RESET;
      fill_q   <= '0;
      oldest_q <= '0;
    end else begin
      if (cfg_we_i) begin
        half_q <= cfg_wdata_i;
      end
      fill_q   <= fill_d;
      oldest_q <= oldest_d;
    end
  end

  // history ring, read of the leaving sample registered at capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      leave_q <= ring_mem[slot[swm_pkg::IDX_W-1:0]];
    end
    if (cmd_i.insert) begin
      ring_mem[wr_addr] <= sample_q;
    end
  end

  // cell chain next value: shift down past the leaving value, or open a gap
  always_comb begin
    for (int i = 0; i < MW; i++) begin
      gt[i] = (swm_pkg::CNT_W'(i) < ins_count) && (cell_q[i] > sample_q);
      ge[i] = (cell_q[i] >= leave_q);
    end
    for (int i = 0; i < MW; i++) begin
      cell_d[i] = cell_q[i];
      if (cmd_i.remove) begin
        if (ge[i] && (i + 1 < MW)) begin
          cell_d[i] = cell_q[(i + 1 < MW) ? i + 1 : i];
        end
      end else if ((swm_pkg::CNT_W'(i) < ins_count) && !gt[i]) begin
        cell_d[i] = cell_q[i];
      end else if ((i > 0) && gt[(i > 0) ? i - 1 : 0]) begin
        cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
      end else begin
        cell_d[i] = sample_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q <= sample_i;
    end
    if (cmd_i.remove || cmd_i.insert) begin
      cell_q <= cell_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_full_q <= 1'b0;
      res_full_q   <= 1'b0;
      full_out_q   <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        phase_full_q <= win_full;
      end
      if (cmd_i.gather) begin
        res_full_q <= win_full;
      end
      if (cmd_i.load_out) begin
        full_out_q <= res_full_q;
      end
    end
  end

  // two level median select
  always_comb begin
    for (int p = 0; p < swm_pkg::NUM_GRP * swm_pkg::LANES; p++) begin
      cell_pad[p] = (p < MW) ? cell_q[(p < MW) ? p : 0] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.gather) begin
      for (int g = 0; g < swm_pkg::NUM_GRP; g++) begin
        grp_q[g] <= cell_pad[{swm_pkg::GRP_W'(g), mid[swm_pkg::LANE_W-1:0]}];
      end
    end
    if (cmd_i.load_out) begin
      median_q <= res_full_q ? grp_q[mid[swm_pkg::IDX_W-1:swm_pkg::LANE_W]] : '0;
    end
  end

  assign median_o      = median_q;
  assign window_full_o = full_out_q;

  // fill count never runs past the window length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= win_len)
    else $error("fill count beyond window length");

  // once full, the oldest pointer stays inside the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.insert && phase_full_q) |=> (oldest_q < win_len))
    else $error("oldest pointer outside window");

endmodule : swm_dpath

`default_nettype wire
